// ===== rtl/core/mua_pkg.sv =====
package mua_pkg;

    localparam int SIZE_W  = 48;
    localparam int LIMIT_W = 48;
    localparam int ERR_W   = 32;

    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_FREE   = 3'd1;
    localparam logic [2:0] CMD_RESIZE = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_RECALC = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ALLOC  = 3'd1,
        OP_FREE   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_RECALC = 3'd4
    } mua_op_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [SIZE_W-1:0] size_a;
        logic [SIZE_W-1:0] size_b;
    } mua_in_t;

    typedef struct packed {
        logic [SIZE_W-1:0] live_bytes;
        logic [SIZE_W-1:0] peak_bytes;
        logic              gc_request;
        logic [ERR_W-1:0]  error_total;
        logic              would_exceed;
    } mua_out_t;

    typedef struct packed {
        logic              valid;
        mua_op_t           op;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] size_a;
    } mua_stage_t;

    typedef struct packed {
        logic               busy;
        logic [LIMIT_W-1:0] limit;
        logic [LIMIT_W-1:0] trigger;
    } mua_limit_t;

endpackage

// ===== rtl/core/mua_decode.sv =====
module mua_decode
    import mua_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  mua_in_t    item,
    output logic       item_stall,
    input  logic       limit_busy,
    input  logic       core_ready,
    output mua_stage_t stage
);

    logic              valid_reg;
    logic              valid_next;
    mua_op_t           op_reg;
    mua_op_t           op_next;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic [SIZE_W-1:0] size_a_reg;
    logic              accept;
    logic              advance;
    logic              grow;
    logic [SIZE_W-1:0] delta;

    // A resize is reduced here to a plain allocate or free of the difference,
    // so the state update only ever sees one add or one subtract.
    assign advance    = valid_reg && core_ready;
    assign item_stall = limit_busy || (valid_reg && !core_ready);
    assign accept     = item_valid && !item_stall;
    assign grow       = item.size_b >= item.size_a;
    assign delta      = grow ? (item.size_b - item.size_a) : (item.size_a - item.size_b);

    always_comb
    begin
        op_next   = OP_NONE;
        size_next = item.size_a;
        unique case (item.command)
            CMD_ALLOC:
            begin
                op_next = (item.size_a != '0) ? OP_ALLOC : OP_NONE;
            end
            CMD_FREE:
            begin
                op_next = (item.size_a != '0) ? OP_FREE : OP_NONE;
            end
            CMD_RESIZE:
            begin
                size_next = delta;
                if (delta == '0)
                begin
                    op_next = OP_NONE;
                end
                else
                begin
                    op_next = grow ? OP_ALLOC : OP_FREE;
                end
            end
            CMD_CLEAR:
            begin
                op_next = OP_CLEAR;
            end
            CMD_RECALC:
            begin
                op_next = OP_RECALC;
            end
            default:
            begin
                op_next = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_next;
            size_reg   <= size_next;
            size_a_reg <= item.size_a;
        end
    end

    assign stage.valid  = valid_reg;
    assign stage.op     = op_reg;
    assign stage.size   = size_reg;
    assign stage.size_a = size_a_reg;

endmodule

// ===== rtl/core/mua_limit.sv =====
module mua_limit
    import mua_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    output mua_limit_t         limit_info
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FOLD  = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_REM   = 5'b01000,
        ST_FIX   = 5'b10000
    } div_state_t;

    localparam logic [LIMIT_W-1:0] DIVISOR = LIMIT_W'(5);

    div_state_t         state_reg;
    logic [1:0]         fold_reg;
    logic [LIMIT_W-1:0] quot_reg;
    logic [LIMIT_W-1:0] prod_reg;
    logic [LIMIT_W-1:0] rem_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] trigger_reg;
    logic [LIMIT_W-1:0] fold_add;
    logic [LIMIT_W-1:0] quarter;
    logic               write;

    // The trigger level is limit minus limit / 5. The quotient starts at three
    // quarters of the limit, is widened toward 0.8 by four shifted adds and is
    // then scaled down by four. It lands at most two below the exact quotient,
    // and a compare and subtract on the remainder closes the gap.
    assign write     = cfg_valid && cfg_ready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign quarter   = quot_reg >> 2;
    assign fold_add  = quot_reg >> (6'd4 << fold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fold_reg    <= '0;
            quot_reg    <= '0;
            prod_reg    <= '0;
            rem_reg     <= '0;
            limit_reg   <= '0;
            trigger_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (write)
                    begin
                        limit_reg <= cfg_data;
                        quot_reg  <= (cfg_data >> 1) + (cfg_data >> 2);
                        fold_reg  <= '0;
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    quot_reg <= quot_reg + fold_add;
                    fold_reg <= fold_reg + 1'b1;
                    if (fold_reg == 2'd3)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    quot_reg  <= quarter;
                    prod_reg  <= {quot_reg[LIMIT_W-1:2], 2'b00} + quarter;
                    state_reg <= ST_REM;
                end
                ST_REM:
                begin
                    rem_reg   <= limit_reg - prod_reg;
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    if (rem_reg >= DIVISOR)
                    begin
                        quot_reg <= quot_reg + 1'b1;
                        rem_reg  <= rem_reg - DIVISOR;
                    end
                    else
                    begin
                        trigger_reg <= limit_reg - quot_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign limit_info.busy    = !cfg_ready;
    assign limit_info.limit   = limit_reg;
    assign limit_info.trigger = trigger_reg;

endmodule

// ===== rtl/core/mua_core.sv =====
module mua_core
    import mua_pkg::*;
#(
    parameter int COUNT_WIDTH = 48
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  mua_stage_t stage,
    input  mua_limit_t limit_info,
    output logic       core_ready,
    output logic       result_valid,
    input  logic       result_stall,
    output mua_out_t   result
);

    localparam int EW = (COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W;
    localparam logic [EW:0] CMAX_E = (EW + 1)'({COUNT_WIDTH{1'b1}});

    logic [COUNT_WIDTH-1:0] live_reg;
    logic [COUNT_WIDTH-1:0] live_next;
    logic [COUNT_WIDTH-1:0] peak_reg;
    logic [COUNT_WIDTH-1:0] peak_next;
    logic                   flag_reg;
    logic                   flag_next;
    logic [ERR_W-1:0]       err_reg;
    logic [ERR_W-1:0]       err_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    mua_out_t               out_word_reg;

    logic                   take;
    logic [EW-1:0]          live_e;
    logic [EW-1:0]          size_e;
    logic [EW-1:0]          trig_e;
    logic [EW:0]            sum;
    logic [EW:0]            reach;
    logic                   ovf;
    logic                   under;
    logic [COUNT_WIDTH-1:0] grown;
    logic [COUNT_WIDTH-1:0] shrunk;
    logic                   limit_on;
    logic                   err_hit;
    logic                   exceed;

    assign core_ready = !out_valid_reg || !result_stall;
    assign take       = stage.valid && core_ready;

    assign live_e   = EW'(live_reg);
    assign size_e   = EW'(stage.size);
    assign trig_e   = EW'(limit_info.trigger);
    assign limit_on = limit_info.limit != '0;

    assign sum    = {1'b0, live_e} + {1'b0, size_e};
    assign ovf    = sum > CMAX_E;
    assign grown  = ovf ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    assign under  = live_e < size_e;
    assign shrunk = under ? '0 : COUNT_WIDTH'(live_e - size_e);

    // With live below the limit, size_a >= limit - live is the same as
    // live + size_a >= limit, and that sum also covers live >= limit.
    assign reach  = {1'b0, live_e} + {1'b0, EW'(stage.size_a)};
    assign exceed = limit_on && (reach >= (EW + 1)'(limit_info.limit));

    always_comb
    begin
        live_next = live_reg;
        peak_next = peak_reg;
        flag_next = flag_reg;
        err_hit   = 1'b0;
        unique case (stage.op)
            OP_ALLOC:
            begin
                live_next = grown;
                err_hit   = ovf;
                if (grown > peak_reg)
                begin
                    peak_next = grown;
                end
                if (limit_on && (EW'(grown) >= trig_e))
                begin
                    flag_next = 1'b1;
                end
            end
            OP_FREE:
            begin
                live_next = shrunk;
                err_hit   = under;
            end
            OP_CLEAR:
            begin
                flag_next = 1'b0;
            end
            OP_RECALC:
            begin
                flag_next = limit_on && (live_e >= trig_e);
            end
            OP_NONE:
            begin
                live_next = live_reg;
            end
            default:
            begin
                live_next = live_reg;
            end
        endcase
        err_next = (err_hit && (err_reg != '1)) ? err_reg + 1'b1 : err_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= '0;
            peak_reg      <= '0;
            flag_reg      <= 1'b0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                live_reg <= live_next;
                peak_reg <= peak_next;
                flag_reg <= flag_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_word_reg.live_bytes   <= SIZE_W'(live_next);
            out_word_reg.peak_bytes   <= SIZE_W'(peak_next);
            out_word_reg.gc_request   <= flag_next;
            out_word_reg.error_total  <= err_next;
            out_word_reg.would_exceed <= exceed;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // The live count is only raised by an allocation, which also raises the peak.
    live_within_peak: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= peak_reg)
        else $error("live count above peak");

    peak_never_falls: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak count decreased");

    err_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != $past(err_reg)) |-> (err_reg == $past(err_reg) + 1'b1))
        else $error("error count moved by other than one");

    state_moves_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(live_reg) && $stable(flag_reg) && $stable(err_reg))
        else $error("state changed without a word taken");

endmodule

// ===== rtl/core/memory_usage_accountant.sv =====
// Channel   Direction  Handshake            Word
// item      in         item_valid/stall     command, size_a, size_b
// result    out        result_valid/stall   live, peak, gc_request, errors, exceed
// cfg       in         cfg_valid/ready      pool byte limit
//
// One word is taken per cycle unless stalled; results are registered after decode.
// The accounting state is updated by one add or subtract and a compare per word.
// After a limit write, the trigger level is worked out by shifted adds and
// remainder fixes; cfg_ready and item acceptance are held off meanwhile.
// Reset clears all counts, the flag and the limit; no clearing pass is needed.
// A stalled result is held, and one more item is still taken into the input stage.
module memory_usage_accountant
    import mua_pkg::*;
#(
    parameter int COUNT_WIDTH = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  mua_in_t            item,
    output logic               result_valid,
    input  logic               result_stall,
    output mua_out_t           result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    mua_limit_t limit_info;
    mua_stage_t stage;
    logic       core_ready;

    mua_limit u_limit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .limit_info (limit_info)
    );

    mua_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .limit_busy (limit_info.busy),
        .core_ready (core_ready),
        .stage      (stage)
    );

    mua_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .limit_info   (limit_info),
        .core_ready   (core_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
